[src/opp_pkg.sv]
`timescale 1ns / 1ps
package opp_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [5:0]  pkt_tag;
        logic [31:0] value;
        logic [3:0]  error_code;
        logic        last;
    } t_out;

    localparam logic [3:0] EV_HEADER  = 4'd0;
    localparam logic [3:0] EV_VERSION = 4'd1;
    localparam logic [3:0] EV_CREATED = 4'd2;
    localparam logic [3:0] EV_DAYS    = 4'd3;
    localparam logic [3:0] EV_ALG     = 4'd4;
    localparam logic [3:0] EV_MBITS   = 4'd5;
    localparam logic [3:0] EV_MBYTE   = 4'd6;
    localparam logic [3:0] EV_UID     = 4'd7;
    localparam logic [3:0] EV_KEYDONE = 4'd8;
    localparam logic [3:0] EV_ERROR   = 4'd9;

    localparam logic [3:0] ER_NONE    = 4'd0;
    localparam logic [3:0] ER_PTAG    = 4'd1;
    localparam logic [3:0] ER_OVERRUN = 4'd2;
    localparam logic [3:0] ER_EARLY   = 4'd3;
    localparam logic [3:0] ER_VERSION = 4'd4;
    localparam logic [3:0] ER_MPI     = 4'd5;
    localparam logic [3:0] ER_UNCONS  = 4'd6;
    localparam logic [3:0] ER_TAG     = 4'd7;
    localparam logic [3:0] ER_ALG     = 4'd8;
    localparam logic [3:0] ER_NEWFMT  = 4'd9;

    localparam logic [5:0] TAG_PUBKEY = 6'd6;
    localparam logic [5:0] TAG_USERID = 6'd13;
    localparam logic [7:0] ALG_DSA    = 8'd17;

endpackage

[src/openpgp_packet_parser_unit.sv]
`timescale 1ns / 1ps
// Old-format packet stream parser.
// Input channel (i_in_valid / o_in_ready / i_in_data): one word per cycle while ready, either
// a stream byte (kind 0) or an end-of-stream mark (kind 1).
// Output channel (o_out_valid / i_out_ready / o_out_data): parse events, one per
// word, in stream order. A byte gives zero to three events.
// Each accepted byte is decoded in the cycle it is taken; its events are registered
// into a four-entry result queue, whose head drives the output.
// Throughput is one byte per cycle while each byte gives at most one event and
// the receiver keeps up; the input stalls whenever the queue has fewer than
// three free entries, so a byte that gives several events holds off the next
// byte until the receiver has taken the extra events.
// Reset empties the queue and returns the parser to waiting for a tag byte.
// After any error other than unconsumed data, bytes are still taken but give
// no events until reset. A stalled receiver simply fills the queue and then
// holds off the input.
module openpgp_packet_parser_unit
    import opp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    typedef enum logic [3:0] {
        PH_TAG, PH_LEN, PH_VER, PH_TIME, PH_DAYS, PH_ALG, PH_MBITS, PH_MDATA, PH_UID
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_plen, n_plen;
    logic [31:0] r_bc, n_bc;
    logic        r_unb, n_unb;
    logic [5:0]  r_tag, n_tag;
    logic [7:0]  r_ver, n_ver;
    logic [7:0]  r_alg, n_alg;
    logic [2:0]  r_mnum, n_mnum;
    logic [13:0] r_mleft, n_mleft;
    logic [3:0]  r_top, n_top;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_fbl, n_fbl;
    logic        r_halted, n_halted;

    t_out        r_q [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;

    t_out        res [3];
    logic [1:0]  nres;
    logic        acc_in, pop;
    logic        do_hdr, st_req;
    t_phase      st_ph;
    logic [13:0] st_nb;
    logic [7:0]  b;
    logic [16:0] bits_p7;
    logic [13:0] nbytes;
    logic [3:0]  topk;
    logic [3:0]  top_new;
    logic [2:0]  mcount;

    assign o_in_ready  = (r_cnt <= 3'd1);
    assign acc_in      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_cnt != 3'd0);
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_data  = r_q[r_rp];
    assign b           = i_in_data.data_byte;

    always_comb begin
        n_phase = r_phase; n_plen = r_plen; n_bc = r_bc; n_unb = r_unb; n_tag = r_tag;
        n_ver = r_ver; n_alg = r_alg; n_mnum = r_mnum; n_mleft = r_mleft; n_top = r_top;
        n_acc = r_acc; n_fbl = r_fbl; n_halted = r_halted;
        nres = 2'd0; do_hdr = 1'b0; st_req = 1'b0; st_ph = PH_TAG; st_nb = 14'd0;
        bits_p7 = 17'd0; nbytes = 14'd0; topk = 4'd0; top_new = 4'd0; mcount = 3'd2;
        for (int i = 0; i < 3; i++) begin
            res[i] = '0;
        end
        if (acc_in && !r_halted) begin
            if (i_in_data.kind) begin
                if (r_phase != PH_TAG) begin
                    res[nres] = '{EV_ERROR, r_tag, 32'd0, ER_EARLY, 1'b0};
                    nres = nres + 2'd1; n_halted = 1'b1;
                end
            end else begin
                case (r_phase)
                    PH_TAG: begin
                        if (!b[7]) begin
                            n_tag = 6'd0;
                            res[nres] = '{EV_ERROR, 6'd0, 32'd0, ER_PTAG, 1'b0};
                            nres = nres + 2'd1; n_halted = 1'b1;
                        end else if (b[6]) begin
                            n_tag = b[5:0];
                            res[nres] = '{EV_ERROR, b[5:0], 32'd0, ER_NEWFMT, 1'b0};
                            nres = nres + 2'd1; n_halted = 1'b1;
                        end else begin
                            n_tag = {2'b00, b[5:2]};
                            n_plen = 32'd0;
                            n_unb = 1'b0;
                            if (b[1:0] == 2'd3) begin
                                n_unb = 1'b1;
                                do_hdr = 1'b1;
                            end else begin
                                n_phase = PH_LEN;
                                n_acc = 32'd0;
                                n_fbl = (b[1:0] == 2'd0) ? 3'd1 :
                                        (b[1:0] == 2'd1) ? 3'd2 : 3'd4;
                            end
                        end
                    end
                    PH_LEN: begin
                        n_plen = {r_plen[23:0], b};
                        if (r_fbl != 3'd0) n_fbl = r_fbl - 3'd1;
                        if (n_fbl == 3'd0) do_hdr = 1'b1;
                    end
                    PH_VER, PH_TIME, PH_DAYS, PH_ALG, PH_MBITS: begin
                        n_bc = r_bc + 32'd1;
                        n_acc = {r_acc[23:0], b};
                        if (r_fbl != 3'd0) n_fbl = r_fbl - 3'd1;
                        if (n_fbl == 3'd0) begin
                            case (r_phase)
                                PH_VER: begin
                                    if (n_acc == 32'd2 || n_acc == 32'd3 || n_acc == 32'd4) begin
                                        n_ver = (n_acc == 32'd2) ? 8'd3 : n_acc[7:0];
                                        res[nres] = '{EV_VERSION, r_tag, {24'd0, n_ver},
                                                      ER_NONE, 1'b0};
                                        nres = nres + 2'd1;
                                        st_req = 1'b1; st_ph = PH_TIME; st_nb = 14'd4;
                                    end else begin
                                        res[nres] = '{EV_ERROR, r_tag, n_acc, ER_VERSION, 1'b0};
                                        nres = nres + 2'd1; n_halted = 1'b1;
                                    end
                                end
                                PH_TIME: begin
                                    res[nres] = '{EV_CREATED, r_tag, n_acc, ER_NONE, 1'b0};
                                    nres = nres + 2'd1;
                                    st_req = 1'b1;
                                    if (r_ver == 8'd3) begin
                                        st_ph = PH_DAYS; st_nb = 14'd2;
                                    end else begin
                                        st_ph = PH_ALG; st_nb = 14'd1;
                                    end
                                end
                                PH_DAYS: begin
                                    res[nres] = '{EV_DAYS, r_tag, n_acc, ER_NONE, 1'b0};
                                    nres = nres + 2'd1;
                                    st_req = 1'b1; st_ph = PH_ALG; st_nb = 14'd1;
                                end
                                PH_ALG: begin
                                    if (n_acc == 32'd1 || n_acc == 32'd2 || n_acc == 32'd3 ||
                                        n_acc == {24'd0, ALG_DSA}) begin
                                        n_alg = n_acc[7:0];
                                        res[nres] = '{EV_ALG, r_tag, n_acc, ER_NONE, 1'b0};
                                        nres = nres + 2'd1;
                                        n_mnum = 3'd0;
                                        st_req = 1'b1; st_ph = PH_MBITS; st_nb = 14'd2;
                                    end else begin
                                        res[nres] = '{EV_ERROR, r_tag, n_acc, ER_ALG, 1'b0};
                                        nres = nres + 2'd1; n_halted = 1'b1;
                                    end
                                end
                                default: begin
                                    if (n_acc[15:0] == 16'd0) begin
                                        res[nres] = '{EV_ERROR, r_tag, 32'd0, ER_MPI, 1'b0};
                                        nres = nres + 2'd1; n_halted = 1'b1;
                                    end else begin
                                        res[nres] = '{EV_MBITS, r_tag, {16'd0, n_acc[15:0]},
                                                      ER_NONE, 1'b0};
                                        nres = nres + 2'd1;
                                        bits_p7 = {1'b0, n_acc[15:0]} + 17'd7;
                                        nbytes = bits_p7[16:3];
                                        // top bit of first byte: bit (bits-1) mod 8
                                        top_new = (n_acc[2:0] != 3'd0) ?
                                                  {1'b0, n_acc[2:0]} : 4'd8;
                                        st_req = 1'b1; st_ph = PH_MDATA; st_nb = nbytes;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_MDATA: begin
                        n_bc = r_bc + 32'd1;
                        topk = r_top;
                        if (topk != 4'd0 && ((({1'b0, b} >> topk) != 9'd0) ||
                                             !b[topk[2:0] - 3'd1])) begin
                            res[nres] = '{EV_ERROR, r_tag, {24'd0, b}, ER_MPI, 1'b0};
                            nres = nres + 2'd1; n_halted = 1'b1;
                        end else begin
                            n_top = 4'd0;
                            n_mleft = r_mleft - 14'd1;
                            res[nres] = '{EV_MBYTE, r_tag, {24'd0, b}, ER_NONE,
                                          n_mleft == 14'd0};
                            nres = nres + 2'd1;
                            if (n_mleft == 14'd0) begin
                                n_mnum = r_mnum + 3'd1;
                                mcount = (r_alg == ALG_DSA) ? 3'd4 : 3'd2;
                                if (n_mnum >= mcount) begin
                                    // key finished
                                    if (!r_unb && n_bc != r_plen) begin
                                        res[nres] = '{EV_ERROR, r_tag, r_plen - n_bc,
                                                      ER_UNCONS, 1'b0};
                                        nres = nres + 2'd1;
                                    end
                                    res[nres] = '{EV_KEYDONE, r_tag, 32'd0, ER_NONE, 1'b0};
                                    nres = nres + 2'd1;
                                    n_phase = PH_TAG;
                                end else begin
                                    st_req = 1'b1; st_ph = PH_MBITS; st_nb = 14'd2;
                                end
                            end
                        end
                    end
                    PH_UID: begin
                        n_bc = r_bc + 32'd1;
                        if (!r_unb && n_bc == r_plen) begin
                            res[nres] = '{EV_UID, r_tag, {24'd0, b}, ER_NONE, 1'b1};
                            n_phase = PH_TAG;
                        end else begin
                            res[nres] = '{EV_UID, r_tag, {24'd0, b}, ER_NONE, 1'b0};
                        end
                        nres = nres + 2'd1;
                    end
                    default: n_phase = PH_TAG;
                endcase
            end

            if (do_hdr) begin
                res[nres] = '{EV_HEADER, n_tag, n_unb ? 32'hFFFF_FFFF : n_plen, ER_NONE, 1'b0};
                nres = nres + 2'd1;
                n_bc = 32'd0;
                if (n_tag == TAG_PUBKEY) begin
                    st_req = 1'b1; st_ph = PH_VER; st_nb = 14'd1;
                end else if (n_tag == TAG_USERID) begin
                    n_phase = (!n_unb && n_plen == 32'd0) ? PH_TAG : PH_UID;
                end else begin
                    res[nres] = '{EV_ERROR, n_tag, {26'd0, n_tag}, ER_TAG, 1'b0};
                    nres = nres + 2'd1; n_halted = 1'b1;
                end
            end

            if (st_req) begin
                if (!n_unb && ({1'b0, n_bc} + {19'd0, st_nb}) > {1'b0, n_plen}) begin
                    res[nres] = '{EV_ERROR, n_tag, 32'd0, ER_OVERRUN, 1'b0};
                    nres = nres + 2'd1; n_halted = 1'b1;
                end else begin
                    n_phase = st_ph;
                    n_acc = 32'd0;
                    n_fbl = st_nb[2:0];
                    if (st_ph == PH_MDATA) begin
                        n_fbl = 3'd0;
                        n_mleft = st_nb;
                        n_top = top_new;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG; r_plen <= '0; r_bc <= '0; r_unb <= 1'b0; r_tag <= '0;
            r_ver <= '0; r_alg <= '0; r_mnum <= '0; r_mleft <= '0; r_top <= '0;
            r_acc <= '0; r_fbl <= '0; r_halted <= 1'b0;
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_phase <= n_phase; r_plen <= n_plen; r_bc <= n_bc; r_unb <= n_unb;
            r_tag <= n_tag; r_ver <= n_ver; r_alg <= n_alg; r_mnum <= n_mnum;
            r_mleft <= n_mleft; r_top <= n_top; r_acc <= n_acc; r_fbl <= n_fbl;
            r_halted <= n_halted;
            r_wp  <= r_wp + nres;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, nres} - {2'b00, pop};
        end
    end

    // push up to three words into the queue
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < nres) r_q[r_wp + 2'(i)] <= res[i];
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue count overflow");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted) else $error("halt cleared without reset");
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> nres == 2'd0) else $error("event after halt");
    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc_in |-> nres == 2'd0) else $error("event without input word");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import opp_pkg::*;

    typedef enum int {
        P_TAG, P_LEN, P_VER, P_TIME, P_DAYS, P_ALG, P_MBITS, P_MDATA, P_UID
    } t_phase;

    localparam int CYCLE_LIMIT = 400000;

    class parse_scoreboard;
        t_out        pending[$];
        int          fails;
        int          nres;
        t_phase      phase;
        logic [31:0] pkt_len;
        logic [31:0] consumed;
        bit          unbounded;
        logic [5:0]  cur_tag;
        logic [7:0]  version;
        logic [7:0]  algorithm;
        logic [2:0]  mpi_idx;
        logic [13:0] mpi_left;
        logic [3:0]  top_pos;
        logic [31:0] acc;
        logic [2:0]  acc_left;
        bit          halted;

        function new();
            fails     = 0;
            phase     = P_TAG;
            pkt_len   = 0;
            consumed  = 0;
            unbounded = 0;
            cur_tag   = 0;
            version   = 0;
            algorithm = 0;
            mpi_idx   = 0;
            mpi_left  = 0;
            top_pos   = 0;
            acc       = 0;
            acc_left  = 0;
            halted    = 0;
        endfunction

        function void post(logic [3:0] ev, logic [31:0] v, logic [3:0] err, logic lst);
            t_out r;
            if (nres >= 3) return;
            r.event_res   = ev;
            r.pkt_tag     = cur_tag;
            r.value       = v;
            r.error_code  = err;
            r.last        = lst;
            pending.push_back(r);
            nres++;
        endfunction

        function void halt(logic [3:0] code, logic [31:0] v);
            post(EV_ERROR, v, code, 1'b0);
            halted = 1;
        endfunction

        // enter a field of n bytes; flag overrun if it does not fit
        function bit open_field(t_phase ph, int n);
            if (!unbounded && {32'd0, consumed} + n > {32'd0, pkt_len}) begin
                halt(ER_OVERRUN, 0);
                return 0;
            end
            phase    = ph;
            acc      = 0;
            acc_left = n[2:0];
            return 1;
        endfunction

        function void header_done();
            post(EV_HEADER, unbounded ? 32'hFFFF_FFFF : pkt_len, ER_NONE, 1'b0);
            consumed = 0;
            if (cur_tag == TAG_PUBKEY)
                void'(open_field(P_VER, 1));
            else if (cur_tag == TAG_USERID)
                phase = (!unbounded && pkt_len == 0) ? P_TAG : P_UID;
            else
                halt(ER_TAG, {26'd0, cur_tag});
        endfunction

        function void key_done();
            if (!unbounded && consumed != pkt_len)
                post(EV_ERROR, pkt_len - consumed, ER_UNCONS, 1'b0);
            post(EV_KEYDONE, 0, ER_NONE, 1'b0);
            phase = P_TAG;
        endfunction

        function void field_done();
            logic [31:0] v;
            logic [15:0] bits;
            int          nb;
            v = acc;
            case (phase)
                P_VER: begin
                    if (v == 2) v = 3;
                    if (v != 3 && v != 4) begin
                        halt(ER_VERSION, v);
                        return;
                    end
                    version = v[7:0];
                    post(EV_VERSION, v, ER_NONE, 1'b0);
                    void'(open_field(P_TIME, 4));
                end
                P_TIME: begin
                    post(EV_CREATED, v, ER_NONE, 1'b0);
                    if (version == 3) void'(open_field(P_DAYS, 2));
                    else void'(open_field(P_ALG, 1));
                end
                P_DAYS: begin
                    post(EV_DAYS, v, ER_NONE, 1'b0);
                    void'(open_field(P_ALG, 1));
                end
                P_ALG: begin
                    if (v != 1 && v != 2 && v != 3 && v != ALG_DSA) begin
                        halt(ER_ALG, v);
                        return;
                    end
                    algorithm = v[7:0];
                    post(EV_ALG, v, ER_NONE, 1'b0);
                    mpi_idx = 0;
                    void'(open_field(P_MBITS, 2));
                end
                P_MBITS: begin
                    bits = v[15:0];
                    if (bits == 0) begin
                        halt(ER_MPI, 0);
                        return;
                    end
                    post(EV_MBITS, {16'd0, bits}, ER_NONE, 1'b0);
                    nb = (int'(bits) + 7) >> 3;
                    if (!open_field(P_MDATA, nb)) return;
                    acc_left = 0;
                    mpi_left = nb[13:0];
                    top_pos  = (bits[2:0] != 0) ? {1'b0, bits[2:0]} : 4'd8;
                end
                default: ;
            endcase
        endfunction

        function void mpi_byte(logic [7:0] b);
            int k;
            k = top_pos;
            if (k != 0) begin
                if ((b >> k) != 0 || b[k-1] == 1'b0) begin
                    halt(ER_MPI, {24'd0, b});
                    return;
                end
                top_pos = 0;
            end
            mpi_left = mpi_left - 1;
            post(EV_MBYTE, {24'd0, b}, ER_NONE, mpi_left == 0);
            if (mpi_left != 0) return;
            mpi_idx = mpi_idx + 1;
            if (mpi_idx >= ((algorithm == ALG_DSA) ? 4 : 2)) key_done();
            else void'(open_field(P_MBITS, 2));
        endfunction

        // note an accepted word and queue the events it should cause
        function void note_word(t_in w);
            logic [7:0] b;
            b    = w.data_byte;
            nres = 0;
            if (halted) return;
            if (w.kind) begin
                if (phase != P_TAG) halt(ER_EARLY, 0);
                return;
            end
            case (phase)
                P_TAG: begin
                    if (!b[7]) begin
                        cur_tag = 0;
                        halt(ER_PTAG, 0);
                    end else if (b[6]) begin
                        cur_tag = b[5:0];
                        halt(ER_NEWFMT, 0);
                    end else begin
                        cur_tag   = {2'b00, b[5:2]};
                        pkt_len   = 0;
                        unbounded = 0;
                        if (b[1:0] == 2'd3) begin
                            unbounded = 1;
                            header_done();
                        end else begin
                            phase    = P_LEN;
                            acc      = 0;
                            acc_left = (b[1:0] == 0) ? 3'd1 : (b[1:0] == 1) ? 3'd2 : 3'd4;
                        end
                    end
                end
                P_LEN: begin
                    pkt_len = {pkt_len[23:0], b};
                    if (acc_left > 0) acc_left--;
                    if (acc_left == 0) header_done();
                end
                P_VER, P_TIME, P_DAYS, P_ALG, P_MBITS: begin
                    consumed++;
                    acc = {acc[23:0], b};
                    if (acc_left > 0) acc_left--;
                    if (acc_left == 0) field_done();
                end
                P_MDATA: begin
                    consumed++;
                    mpi_byte(b);
                end
                P_UID: begin
                    consumed++;
                    if (!unbounded && consumed == pkt_len) begin
                        post(EV_UID, {24'd0, b}, ER_NONE, 1'b1);
                        phase = P_TAG;
                    end else begin
                        post(EV_UID, {24'd0, b}, ER_NONE, 1'b0);
                    end
                end
                default: phase = P_TAG;
            endcase
        endfunction

        function void check_event(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                $error("unexpected event %0d value %0h", got.event_res, got.value);
                fails++;
                return;
            end
            want = pending.pop_front();
            if (got.event_res !== want.event_res) begin
                $error("event_res exp %0d got %0d", want.event_res, got.event_res);
                fails++;
            end
            if (got.pkt_tag !== want.pkt_tag) begin
                $error("pkt_tag exp %0d got %0d", want.pkt_tag, got.pkt_tag);
                fails++;
            end
            if (got.value !== want.value) begin
                $error("value exp %0h got %0h", want.value, got.value);
                fails++;
            end
            if (got.error_code !== want.error_code) begin
                $error("error_code exp %0d got %0d", want.error_code, got.error_code);
                fails++;
            end
            if (got.last !== want.last) begin
                $error("last exp %0b got %0b", want.last, got.last);
                fails++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    parse_scoreboard sb = new();
    int   cycles = 0;
    bit   steady = 0;
    int   words_sent = 0;
    logic [7:0] body[$];

    always #1 i_clk = ~i_clk;

    openpgp_packet_parser_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // receiver: check accepted events, then pick ready for the next cycle
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) sb.check_event(o_out_data);
            i_out_ready <= steady ? 1'b1 : (pick_gap() == 0);
        end
    end

    task automatic send_word(logic kind, logic [7:0] b);
        t_in w;
        int  gap;
        gap    = pick_gap();
        w.kind = kind;
        w.data_byte = b;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic send_body();
        foreach (body[i]) send_word(1'b0, body[i]);
    endtask

    task automatic add_mpi(int bits);
        int k;
        int nb;
        logic [7:0] first;
        k     = (bits % 8 != 0) ? bits % 8 : 8;
        nb    = (bits + 7) / 8;
        first = 8'((32'd1 << (k - 1)) | ($urandom() & ((32'd1 << (k - 1)) - 1)));
        body.push_back(bits[15:8]);
        body.push_back(bits[7:0]);
        body.push_back(first);
        for (int i = 1; i < nb; i++) body.push_back(8'($urandom()));
    endtask

    // build a public key packet body; max_time forces an all-ones creation time
    task automatic build_key(int ver, int alg, bit max_time, bit wide);
        logic [31:0] t;
        int          bits;
        body.delete();
        t = max_time ? 32'hFFFF_FFFF : $urandom();
        body.push_back(ver[7:0]);
        for (int i = 3; i >= 0; i--) body.push_back(t[8*i +: 8]);
        if (ver != 4) begin
            body.push_back(8'($urandom()));
            body.push_back(8'($urandom()));
        end
        body.push_back(alg[7:0]);
        for (int m = 0; m < ((alg == ALG_DSA) ? 4 : 2); m++) begin
            bits = wide ? $urandom_range(65, 200) : $urandom_range(1, 40);
            if (m == 0 && !wide) bits = ($urandom_range(0, 1) != 0) ? 1 : 8;
            add_mpi(bits);
        end
    endtask

    // prepend an old-format header; lt 3 means indeterminate length
    task automatic put_header(int tag, int lt, logic [31:0] len);
        if (lt == 0 && len > 255) lt = 1;
        if (lt == 1 && len > 65535) lt = 2;
        if (lt == 2) begin
            body.push_front(len[7:0]);
            body.push_front(len[15:8]);
            body.push_front(len[23:16]);
            body.push_front(len[31:24]);
        end else if (lt == 1) begin
            body.push_front(len[7:0]);
            body.push_front(len[15:8]);
        end else if (lt == 0) begin
            body.push_front(len[7:0]);
        end
        body.push_front(8'(8'h80 | (tag << 2) | lt));
    endtask

    task automatic key_packet(int ver, int alg, int lt, int extra, bit max_time, bit wide);
        build_key(ver, alg, max_time, wide);
        put_header(TAG_PUBKEY, lt, body.size() + ((lt == 3) ? 0 : extra));
        send_body();
    endtask

    task automatic uid_packet(int n, int lt);
        body.delete();
        for (int i = 0; i < n; i++) body.push_back(8'($urandom()));
        put_header(TAG_USERID, lt, n);
        send_body();
    endtask

    function automatic int pick_alg();
        case ($urandom_range(0, 3))
            0: return 1;
            1: return 2;
            2: return 3;
            default: return ALG_DSA;
        endcase
    endfunction

    // one halting error, chosen at random, then bytes that must be ignored
    task automatic halting_case();
        int sel;
        int cut;
        sel = $urandom_range(0, 9);
        body.delete();
        case (sel)
            0: body.push_back(8'($urandom_range(0, 127)));
            1: body.push_back(8'(8'hC0 | $urandom_range(0, 63)));
            2: begin
                body.push_back(8'(8'h80 | ($urandom_range(0, 5) << 2)));
                body.push_back(8'd1);
            end
            3: begin
                build_key(4, pick_alg(), 0, 0);
                cut = $urandom_range(0, body.size() - 1);
                put_header(TAG_PUBKEY, 2, cut);
            end
            4: begin
                build_key(3, pick_alg(), 0, 0);
                put_header(TAG_PUBKEY, 0, body.size());
                cut = $urandom_range(1, body.size() - 1);
                while (body.size() > cut) void'(body.pop_back());
            end
            5: body = '{8'h9B, 8'(5 + $urandom_range(0, 200))};
            6: body = '{8'h9B, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'(4 + $urandom_range(0, 12))};
            7: body = '{8'h9B, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0};
            8: body = '{8'h9B, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd9,
                        8'(8'h80 | $urandom_range(0, 127))};
            default: begin
                body = '{8'hB7};
                for (int i = 0; i < 5; i++) body.push_back(8'($urandom()));
            end
        endcase
        send_body();
        // early end for the truncated key and the open-ended user ID
        if (sel == 4 || sel == 9) send_word(1'b1, 8'h00);
        for (int i = 0; i < 6; i++) send_word(1'($urandom_range(0, 1)), 8'($urandom()));
    endtask

    initial begin
        int wait_cycles;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every version, algorithm and length form, field extremes
        send_word(1'b1, 8'hFF);
        key_packet(2, 1, 0, 0, 1, 0);
        uid_packet(0, 0);
        key_packet(3, 2, 1, 2, 0, 0);
        uid_packet(3, 2);
        key_packet(4, ALG_DSA, 2, 0, 0, 0);
        key_packet(4, 3, 3, 0, 0, 0);

        // random well-formed packets with random content
        while (words_sent < 170) begin
            steady = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 5))
                0, 1, 2: key_packet($urandom_range(2, 4), pick_alg(), $urandom_range(0, 3),
                                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : 0,
                                    0, $urandom_range(0, 15) == 0);
                3, 4: uid_packet($urandom_range(0, 12), $urandom_range(0, 2));
                default: send_word(1'b1, 8'($urandom()));
            endcase
        end
        steady = 0;
        halting_case();
        i_in_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[filelist.f]
src/opp_pkg.sv
src/openpgp_packet_parser_unit.sv
tb/sv/tb_top.sv
